[sv/assert_macros.svh]
// Assertion macros shared by the vector ARMA filter RTL.
// Users must have clk_i and rst_ni in scope; NO_ASSERTIONS compiles them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising clock edge outside reset.
`define VAF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("vaf assertion failed");

// Check that a condition never holds outside reset.
`define VAF_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("vaf forbidden condition seen");

`else

`define VAF_ASSERT(lbl, prop)
`define VAF_ASSERT_NEVER(lbl, expr)

`endif

`endif

[sv/vaf_pkg.sv]
// Shared types and constants of the vector ARMA filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package vaf_pkg;

  // Sample and coefficient format
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_FRAC   = 14;

  // Vector size and field widths
  localparam int MAX_DIM = 4;
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int DIMC_W  = $clog2(MAX_DIM + 1);
  localparam int FUNC_W  = 2;
  localparam int TAP_W   = 3;
  localparam int ORD_W   = 4;
  localparam int REG_W   = 2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // Input item function codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_NOISE = 2'd0,
    FUNC_AR    = 2'd1,
    FUNC_MA    = 2'd2
  } func_e;

  // Configuration register indexes
  typedef enum logic [REG_W-1:0] {
    REG_AR_ORDER  = 2'd0,
    REG_MA_ORDER  = 2'd1,
    REG_DIMENSION = 2'd2
  } reg_e;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic init;  // load accumulator with the scaled noise sample
    logic step;  // a coefficient/history pair is presented
    logic sub;   // subtract the product (AR term) instead of adding
  } mac_ctrl_t;

endpackage

`default_nettype wire

[sv/vaf_coef_mem.sv]
// Coefficient memory with one write port, one registered read port and
// per-entry valid bits so that unwritten entries read as zero. Uses vaf_pkg.
`default_nettype none

module vaf_coef_mem
  import vaf_pkg::*;
#(
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  logic [AW-1:0] waddr_i,
  input  sample_t       wdata_i,
  input  logic [AW-1:0] raddr_i,
  output sample_t       rdata_o
);

  sample_t          mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  sample_t          rdata_q;
  logic             hit_q;

  // Write the array
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Mark written entries; reset clears the whole table at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      hit_q <= valid_q[raddr_i];
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = hit_q ? rdata_q : '0;

endmodule

`default_nettype wire

[sv/vaf_mac.sv]
// Shared multiply-accumulate unit: registered product, wide accumulator,
// round to nearest and saturation of the result. Uses vaf_pkg and the macros.
`default_nettype none
`include "assert_macros.svh"

module vaf_mac
  import vaf_pkg::*;
#(
  parameter int ACC_W = 40
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  mac_ctrl_t ctrl_i,
  input  sample_t   init_i,
  input  sample_t   coef_i,
  input  sample_t   hist_i,
  output logic      busy_o,
  output sample_t   result_o,
  output logic      sat_o
);

  localparam logic signed [ACC_W-1:0] HI   = ACC_W'((2 ** (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] LO   = ~HI;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(2 ** (COEF_FRAC - 1));

  logic signed [2*SAMPLE_BITS-1:0] prod_d;
  logic signed [2*SAMPLE_BITS-1:0] prod_q;
  logic                            p_valid_q;
  logic                            p_sub_q;
  logic signed [ACC_W-1:0]         acc_q;
  logic signed [ACC_W-1:0]         rnd;
  logic signed [ACC_W-1:0]         shifted;

  assign prod_d = coef_i * hist_i;

  // Track the product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else begin
      p_valid_q <= ctrl_i.step;
    end
  end

  // Hold the product and its sign
  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    p_sub_q <= ctrl_i.sub;
  end

  // Load or advance the accumulator
  always_ff @(posedge clk_i) begin
    if (ctrl_i.init) begin
      acc_q <= ACC_W'(init_i) <<< COEF_FRAC;
    end else if (p_valid_q) begin
      if (p_sub_q) begin
        acc_q <= acc_q - ACC_W'(prod_q);
      end else begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  // Round to nearest, ties up, then clip to the sample range
  always_comb begin
    rnd     = acc_q + HALF;
    shifted = rnd >>> COEF_FRAC;
    sat_o   = 1'b0;
    if (shifted > HI) begin
      result_o = HI[SAMPLE_BITS-1:0];
      sat_o    = 1'b1;
    end else if (shifted < LO) begin
      result_o = LO[SAMPLE_BITS-1:0];
      sat_o    = 1'b1;
    end else begin
      result_o = shifted[SAMPLE_BITS-1:0];
    end
  end

  assign busy_o = p_valid_q;

  // A fresh accumulation never starts while a product is still in flight
  `VAF_ASSERT(a_init_drained, ctrl_i.init |-> !p_valid_q)

endmodule

`default_nettype wire

[sv/vector_arma_filter.sv]
// Vector ARMA filter driven by noise samples.
// Top level: sequencer, history registers, two coefficient memories and the
// shared multiply-accumulate unit. Uses vaf_pkg, vaf_coef_mem, vaf_mac, macros.
//
// Usage: input items arrive on in_valid_i/in_stall_o. func_i selects a noise
// component (components of one time step arrive in order 0 to dimension-1),
// an AR coefficient write or an MA coefficient write at (tap_i,row_i,col_i).
// Coefficient writes and all but the last noise component are only stored.
// The last component starts the step: for each row r the unit loads
// noise[r] << 14, then feeds one product per cycle through the single
// 16x16 multiplier, dimension*(ar_order+ma_order) products per row, then
// drains the pipeline and hands the result off; after the last row it
// shifts the histories. in_stall_o is high for the whole step. Results
// leave on out_valid_o/out_stall_i through an output register, one per
// component, last_o on the final one; a stalled receiver holds that
// register and pauses the sequencer before the next row.
// Reset clears the configuration (orders 0, dimension 1), the histories, the
// component count and every coefficient at once; no clearing pass is needed.
// Configuration writes on cfg_valid_i/cfg_ready_o are always taken.
`default_nettype none
`include "assert_macros.svh"

module vector_arma_filter
  import vaf_pkg::*;
#(
  parameter int MAX_AR = 8,
  parameter int MAX_MA = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input items
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [FUNC_W-1:0] func_i,
  input  sample_t           value_i,
  input  logic [TAP_W-1:0]  tap_i,
  input  logic [DIM_W-1:0]  row_i,
  input  logic [DIM_W-1:0]  col_i,
  // result items
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DIM_W-1:0]  component_o,
  output sample_t           out_value_o,
  output logic              last_o,
  output logic              saturated_o,
  // configuration writes
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [REG_W-1:0]  cfg_index_i,
  input  logic [ORD_W-1:0]  cfg_data_i
);

  localparam int AR_W  = (MAX_AR > 1) ? $clog2(MAX_AR) : 1;
  localparam int MA_W  = (MAX_MA > 1) ? $clog2(MAX_MA) : 1;
  localparam int AR_AW = $clog2(MAX_AR * MAX_DIM * MAX_DIM);
  localparam int MA_AW = $clog2(MAX_MA * MAX_DIM * MAX_DIM);
  localparam int ACC_W = 2 * SAMPLE_BITS + $clog2((MAX_AR + MAX_MA) * MAX_DIM + 2) + 1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOAD  = 6'b000010,
    ST_RUN   = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_EMIT  = 6'b010000,
    ST_SHIFT = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  logic [ORD_W-1:0]    ar_order_q, ma_order_q;
  logic [DIMC_W-1:0]   dimension_q;
  logic [DIM_W-1:0]    comp_cnt_q;
  logic [DIM_W-1:0]    row_q, col_q;
  logic [AR_W-1:0]     ar_tap_q;
  logic [MA_W-1:0]     ma_tap_q;
  logic                ma_phase_q;
  logic                s1_valid_q, s1_sub_q;
  sample_t             s1_hist_q;
  logic                out_valid_q;
  logic [DIM_W-1:0]    component_q;
  sample_t             out_value_q;
  logic                last_q, sat_q;

  sample_t             pend_q  [MAX_DIM];
  sample_t             newx_q  [MAX_DIM];
  sample_t             x_hist_q [MAX_AR][MAX_DIM];
  sample_t             n_hist_q [MAX_MA][MAX_DIM];

  logic [DIMC_W-1:0]   dim_eff;
  logic [ORD_W-1:0]    ar_p, ma_p;
  logic                in_acc, noise_acc, step_go;
  logic                col_last, row_last, ar_tap_last, ma_tap_last, term_last;
  logic                has_terms, out_free;
  logic                ar_wr, ma_wr;
  logic [AR_AW-1:0]    ar_waddr, ar_raddr;
  logic [MA_AW-1:0]    ma_waddr, ma_raddr;
  sample_t             ar_coef, ma_coef;
  mac_ctrl_t           mac_ctrl;
  logic                mac_busy;
  sample_t             mac_result;
  logic                mac_sat;

  // Effective configuration
  always_comb begin
    if (dimension_q == '0) begin
      dim_eff = DIMC_W'(1);
    end else if (32'(dimension_q) > MAX_DIM) begin
      dim_eff = DIMC_W'(MAX_DIM);
    end else begin
      dim_eff = dimension_q;
    end
    ar_p = (32'(ar_order_q) > MAX_AR) ? ORD_W'(MAX_AR) : ar_order_q;
    ma_p = (32'(ma_order_q) > MAX_MA) ? ORD_W'(MAX_MA) : ma_order_q;
  end

  // Handshake and item decode
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign noise_acc   = in_acc && (func_i == FUNC_NOISE);
  assign step_go     = noise_acc && (DIMC_W'(comp_cnt_q) + DIMC_W'(1) >= dim_eff);
  assign ar_wr       = in_acc && (func_i == FUNC_AR) && (32'(tap_i) < MAX_AR);
  assign ma_wr       = in_acc && (func_i == FUNC_MA) && (32'(tap_i) < MAX_MA);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // Term walk: AR taps then MA taps, columns innermost
  assign col_last    = (DIMC_W'(col_q) + DIMC_W'(1) == dim_eff);
  assign row_last    = (DIMC_W'(row_q) + DIMC_W'(1) == dim_eff);
  assign ar_tap_last = (32'(ar_tap_q) + 32'd1 == 32'(ar_p));
  assign ma_tap_last = (32'(ma_tap_q) + 32'd1 == 32'(ma_p));
  assign has_terms   = (ar_p != '0) || (ma_p != '0);
  assign term_last   = col_last && (ma_phase_q ? ma_tap_last
                                               : (ar_tap_last && (ma_p == '0)));

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ar_order_q  <= '0;
      ma_order_q  <= '0;
      dimension_q <= DIMC_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_AR_ORDER:  ar_order_q  <= cfg_data_i;
        REG_MA_ORDER:  ma_order_q  <= cfg_data_i;
        REG_DIMENSION: dimension_q <= cfg_data_i[DIMC_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (step_go) state_d = ST_LOAD;
      ST_LOAD:  state_d = has_terms ? ST_RUN : ST_DRAIN;
      ST_RUN:   if (term_last) state_d = ST_DRAIN;
      ST_DRAIN: if (!s1_valid_q && !mac_busy) state_d = ST_EMIT;
      ST_EMIT:  if (out_free) state_d = row_last ? ST_SHIFT : ST_LOAD;
      ST_SHIFT: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer registers and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      comp_cnt_q <= '0;
      row_q      <= '0;
      col_q      <= '0;
      ar_tap_q   <= '0;
      ma_tap_q   <= '0;
      ma_phase_q <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      s1_valid_q <= (state_q == ST_RUN);
      if (noise_acc) begin
        comp_cnt_q <= step_go ? '0 : comp_cnt_q + DIM_W'(1);
      end
      if (step_go) begin
        row_q <= '0;
      end
      if (state_q == ST_LOAD) begin
        col_q      <= '0;
        ar_tap_q   <= '0;
        ma_tap_q   <= '0;
        ma_phase_q <= (ar_p == '0);
      end
      // advance column, then tap, then switch from AR to MA
      if (state_q == ST_RUN) begin
        if (col_last) begin
          col_q <= '0;
          if (!ma_phase_q) begin
            if (ar_tap_last) begin
              ma_phase_q <= 1'b1;
            end else begin
              ar_tap_q <= ar_tap_q + AR_W'(1);
            end
          end else if (!ma_tap_last) begin
            ma_tap_q <= ma_tap_q + MA_W'(1);
          end
        end else begin
          col_q <= col_q + DIM_W'(1);
        end
      end
      if ((state_q == ST_EMIT) && out_free) begin
        row_q <= row_q + DIM_W'(1);
      end
    end
  end

  // Capture noise components of the current step
  always_ff @(posedge clk_i) begin
    if (noise_acc) begin
      pend_q[comp_cnt_q] <= value_i;
    end
  end

  // Read the history operand alongside the coefficient memories
  always_ff @(posedge clk_i) begin
    s1_sub_q  <= !ma_phase_q;
    s1_hist_q <= ma_phase_q ? n_hist_q[ma_tap_q][col_q] : x_hist_q[ar_tap_q][col_q];
  end

  // Shift both histories once all rows are out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_AR; i++) begin
        for (int c = 0; c < MAX_DIM; c++) begin
          x_hist_q[i][c] <= '0;
        end
      end
      for (int j = 0; j < MAX_MA; j++) begin
        for (int c = 0; c < MAX_DIM; c++) begin
          n_hist_q[j][c] <= '0;
        end
      end
    end else if (state_q == ST_SHIFT) begin
      for (int i = MAX_AR - 1; i > 0; i--) begin
        x_hist_q[i] <= x_hist_q[i-1];
      end
      for (int j = MAX_MA - 1; j > 0; j--) begin
        n_hist_q[j] <= n_hist_q[j-1];
      end
      for (int c = 0; c < MAX_DIM; c++) begin
        x_hist_q[0][c] <= (DIMC_W'(c) < dim_eff) ? newx_q[c] : '0;
        n_hist_q[0][c] <= (DIMC_W'(c) < dim_eff) ? pend_q[c] : '0;
      end
    end
  end

  // Coefficient memories
  assign ar_waddr = AR_AW'({AR_W'(tap_i), row_i, col_i});
  assign ma_waddr = MA_AW'({MA_W'(tap_i), row_i, col_i});
  assign ar_raddr = AR_AW'({ar_tap_q, row_q, col_q});
  assign ma_raddr = MA_AW'({ma_tap_q, row_q, col_q});

  vaf_coef_mem #(
    .DEPTH (MAX_AR * MAX_DIM * MAX_DIM)
  ) u_ar_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (ar_wr),
    .waddr_i (ar_waddr),
    .wdata_i (value_i),
    .raddr_i (ar_raddr),
    .rdata_o (ar_coef)
  );

  vaf_coef_mem #(
    .DEPTH (MAX_MA * MAX_DIM * MAX_DIM)
  ) u_ma_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (ma_wr),
    .waddr_i (ma_waddr),
    .wdata_i (value_i),
    .raddr_i (ma_raddr),
    .rdata_o (ma_coef)
  );

  // Shared multiply-accumulate unit
  assign mac_ctrl.init = (state_q == ST_LOAD);
  assign mac_ctrl.step = s1_valid_q;
  assign mac_ctrl.sub  = s1_sub_q;

  vaf_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .init_i   (pend_q[row_q]),
    .coef_i   (s1_sub_q ? ar_coef : ma_coef),
    .hist_i   (s1_hist_q),
    .busy_o   (mac_busy),
    .result_o (mac_result),
    .sat_o    (mac_sat)
  );

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_EMIT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload and the new process value of this row
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_EMIT) && out_free) begin
      component_q   <= row_q;
      out_value_q   <= mac_result;
      last_q        <= row_last;
      sat_q         <= mac_sat;
      newx_q[row_q] <= mac_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign component_o = component_q;
  assign out_value_o = out_value_q;
  assign last_o      = last_q;
  assign saturated_o = sat_q;

  `VAF_ASSERT(a_emit_drained, (state_q == ST_EMIT) |-> (!s1_valid_q && !mac_busy))
  `VAF_ASSERT(a_run_issues, (state_q == ST_RUN) |=> s1_valid_q)
  `VAF_ASSERT(a_shift_count_clear, (state_q == ST_SHIFT) |-> (comp_cnt_q == '0))
  `VAF_ASSERT(a_out_from_emit, $rose(out_valid_q) |-> $past(state_q == ST_EMIT))

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench of vector_arma_filter: directed and random items
// with a built-in predictor. Depends on vaf_pkg and the vector_arma_filter RTL.

module tb_top;
  import vaf_pkg::*;

  localparam int AR_TAPS         = 8;
  localparam int MA_TAPS         = 8;
  localparam int PHASE_ITEMS     = 40;
  localparam int HOLD_CYCLES     = 600;
  localparam int SETTLE_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int MAX_REPORTS     = 10;
  localparam longint SAMPLE_HI   = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_LO   = -SAMPLE_HI - 1;
  // Spare function code, ignored by the block
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    sample_t           value;
    logic [TAP_W-1:0]  tap;
    logic [DIM_W-1:0]  row;
    logic [DIM_W-1:0]  col;
  } filt_item_t;

  typedef struct packed {
    logic [DIM_W-1:0] component;
    sample_t          value;
    logic             last;
    logic             saturated;
  } filt_result_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [FUNC_W-1:0] func_i      = '0;
  sample_t           value_i     = '0;
  logic [TAP_W-1:0]  tap_i       = '0;
  logic [DIM_W-1:0]  row_i       = '0;
  logic [DIM_W-1:0]  col_i       = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [DIM_W-1:0]  component_o;
  sample_t           out_value_o;
  logic              last_o;
  logic              saturated_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [REG_W-1:0]  cfg_index_i = '0;
  logic [ORD_W-1:0]  cfg_data_i  = '0;

  filt_item_t   pending_items[$];
  filt_result_t expected_outputs[$];
  filt_item_t   on_port;
  filt_result_t want_result;

  // Filter state as the predictor sees it
  sample_t ar_coef    [AR_TAPS][MAX_DIM][MAX_DIM];
  sample_t ma_coef    [MA_TAPS][MAX_DIM][MAX_DIM];
  sample_t x_hist     [AR_TAPS][MAX_DIM];
  sample_t noise_hist [MA_TAPS][MAX_DIM];
  sample_t noise_buf  [MAX_DIM];
  int      fill_count = 0;
  int      cfg_ar     = 0;
  int      cfg_ma     = 0;
  int      cfg_dim    = 1;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int mismatches    = 0;
  int items_in      = 0;
  int results_seen  = 0;
  int sat_seen      = 0;
  int reg_writes    = 0;
  int settings_run  = 0;

  // Clock: period 10
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  vector_arma_filter #(
    .MAX_AR(AR_TAPS),
    .MAX_MA(MA_TAPS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .value_i    (value_i),
    .tap_i      (tap_i),
    .row_i      (row_i),
    .col_i      (col_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .component_o(component_o),
    .out_value_o(out_value_o),
    .last_o     (last_o),
    .saturated_o(saturated_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // Apply one accepted item to the filter state; queue any results it causes
  function automatic void predict_item(input filt_item_t it);
    int dim, p, q, r, c, i;
    longint acc;
    sample_t new_x [MAX_DIM];
    filt_result_t res;
    dim = (cfg_dim < 1) ? 1 : ((cfg_dim > MAX_DIM) ? MAX_DIM : cfg_dim);
    p = (cfg_ar > AR_TAPS) ? AR_TAPS : cfg_ar;
    q = (cfg_ma > MA_TAPS) ? MA_TAPS : cfg_ma;
    if (it.func == FUNC_AR) begin
      ar_coef[it.tap][it.row][it.col] = it.value;
      return;
    end
    if (it.func == FUNC_MA) begin
      ma_coef[it.tap][it.row][it.col] = it.value;
      return;
    end
    if (it.func != FUNC_NOISE) return;
    noise_buf[fill_count] = it.value;
    if (fill_count + 1 < dim) begin
      fill_count++;
      return;
    end
    fill_count = 0;
    for (r = 0; r < dim; r++) begin
      acc = longint'(noise_buf[r]) <<< COEF_FRAC;
      for (i = 0; i < p; i++)
        for (c = 0; c < dim; c++)
          acc -= longint'(ar_coef[i][r][c]) * longint'(x_hist[i][c]);
      for (i = 0; i < q; i++)
        for (c = 0; c < dim; c++)
          acc += longint'(ma_coef[i][r][c]) * longint'(noise_hist[i][c]);
      // Round half up, then clip to the sample range
      acc = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
      res.saturated = 1'b0;
      if (acc > SAMPLE_HI) begin
        acc = SAMPLE_HI;
        res.saturated = 1'b1;
      end else if (acc < SAMPLE_LO) begin
        acc = SAMPLE_LO;
        res.saturated = 1'b1;
      end
      new_x[r] = acc[SAMPLE_BITS-1:0];
      res.component = r[DIM_W-1:0];
      res.value = new_x[r];
      res.last = (r == dim - 1);
      expected_outputs.push_back(res);
    end
    // Advance both histories; unused components shift in zero
    for (i = AR_TAPS - 1; i > 0; i--)
      for (c = 0; c < MAX_DIM; c++) x_hist[i][c] = x_hist[i-1][c];
    for (i = MA_TAPS - 1; i > 0; i--)
      for (c = 0; c < MAX_DIM; c++) noise_hist[i][c] = noise_hist[i-1][c];
    for (c = 0; c < MAX_DIM; c++) begin
      x_hist[0][c] = (c < dim) ? new_x[c] : '0;
      noise_hist[0][c] = (c < dim) ? noise_buf[c] : '0;
    end
  endfunction

  function automatic filt_item_t make_item(input logic [FUNC_W-1:0] f, input int v,
                                           input int t, input int r, input int c);
    filt_item_t it;
    it.func = f;
    it.value = v[SAMPLE_BITS-1:0];
    it.tap = t[TAP_W-1:0];
    it.row = r[DIM_W-1:0];
    it.col = c[DIM_W-1:0];
    return it;
  endfunction

  // Mostly noise, some coefficient updates, a few spare codes
  function automatic filt_item_t random_item();
    int pick, v;
    logic [FUNC_W-1:0] f;
    pick = $urandom_range(99);
    if (pick < 64) begin
      f = FUNC_NOISE;
      v = $urandom_range(1) ? int'($urandom) : int'($urandom_range(4095)) - 2048;
    end else begin
      f = (pick < 80) ? FUNC_AR : ((pick < 96) ? FUNC_MA : FUNC_SPARE);
      v = ($urandom_range(9) < 7) ? int'($urandom_range(6000)) - 3000 : int'($urandom);
    end
    return make_item(f, v, $urandom_range(7), $urandom_range(3), $urandom_range(3));
  endfunction

  // Driver: present queued items, hold the payload while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_item(on_port);
        items_in++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_port = pending_items.pop_front();
          in_valid_i <= 1'b1;
          func_i <= on_port.func;
          value_i <= on_port.value;
          tap_i <= on_port.tap;
          row_i <= on_port.row;
          col_i <= on_port.col;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (hold_served != hold_requests) begin
      out_stall_i <= 1'b1;
      hold_served++;
      hold_left = HOLD_CYCLES;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (saturated_o) sat_seen++;
      if (expected_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: unexpected result: component %0d value %0d last %0b sat %0b",
                   component_o, out_value_o, last_o, saturated_o);
      end else begin
        want_result = expected_outputs.pop_front();
        if (component_o !== want_result.component || out_value_o !== want_result.value ||
            last_o !== want_result.last || saturated_o !== want_result.saturated) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("ERROR: result %0d: expected comp %0d value %0d last %0b sat %0b, %s",
                     results_seen, want_result.component, want_result.value,
                     want_result.last, want_result.saturated,
                     $sformatf("got comp %0d value %0d last %0b sat %0b",
                               component_o, out_value_o, last_o, saturated_o));
        end
      end
    end
  end

  // Watchdog: end the run when no handshake happens for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
               quiet_cycles, expected_outputs.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input reg_e idx, input int data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data[ORD_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_AR_ORDER:  cfg_ar = data & 'hF;
      REG_MA_ORDER:  cfg_ma = data & 'hF;
      REG_DIMENSION: cfg_dim = data & 'h7;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic configure(input int ar, input int ma, input int dim);
    write_reg(REG_AR_ORDER, ar);
    write_reg(REG_MA_ORDER, ma);
    write_reg(REG_DIMENSION, dim);
    settings_run++;
  endtask

  // Wait until every item is in and every result is out, then let the block settle
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid_i || expected_outputs.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_SENDER:   begin send_idle_pct = 70; stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 70; end
      IDLE_BOTH:     begin send_idle_pct = 17; stall_pct = 17; end
      default:       begin send_idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  task automatic random_phase(input int ar, input int ma, input int dim,
                              input idle_mode_e mode, input bit hold_off);
    int n;
    configure(ar, ma, dim);
    set_idle(mode);
    for (n = 0; n < PHASE_ITEMS; n++) pending_items.push_back(random_item());
    if (hold_off) hold_requests++;
    wait_idle();
    set_idle(IDLE_NONE);
  endtask

  initial begin
    int t, r, c;
    // Clear the predicted state to its reset values
    for (t = 0; t < AR_TAPS; t++)
      for (r = 0; r < MAX_DIM; r++) begin
        x_hist[t][r] = '0;
        for (c = 0; c < MAX_DIM; c++) ar_coef[t][r][c] = '0;
      end
    for (t = 0; t < MA_TAPS; t++)
      for (r = 0; r < MAX_DIM; r++) begin
        noise_hist[t][r] = '0;
        for (c = 0; c < MAX_DIM; c++) ma_coef[t][r][c] = '0;
      end
    for (r = 0; r < MAX_DIM; r++) noise_buf[r] = '0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // No taps, one component: noise passes straight through
    pending_items.push_back(make_item(FUNC_NOISE, 32767, 0, 0, 0));
    pending_items.push_back(make_item(FUNC_NOISE, -32768, 7, 3, 3));
    pending_items.push_back(make_item(FUNC_NOISE, 0, 0, 0, 0));
    pending_items.push_back(make_item(FUNC_NOISE, -1, 0, 0, 0));
    pending_items.push_back(make_item(FUNC_NOISE, 1, 0, 0, 0));
    pending_items.push_back(make_item(FUNC_SPARE, -1, 7, 3, 3));
    wait_idle();

    // Extreme coefficients drive the results into positive saturation
    configure(1, 1, 2);
    pending_items.push_back(make_item(FUNC_AR, -32768, 0, 0, 0));
    pending_items.push_back(make_item(FUNC_AR, 32767, 0, 1, 1));
    pending_items.push_back(make_item(FUNC_MA, 32767, 0, 1, 0));
    pending_items.push_back(make_item(FUNC_MA, -32768, 7, 3, 3));
    pending_items.push_back(make_item(FUNC_AR, 32767, 7, 3, 3));
    pending_items.push_back(make_item(FUNC_NOISE, 32767, 0, 0, 0));
    pending_items.push_back(make_item(FUNC_NOISE, 32767, 0, 0, 0));
    pending_items.push_back(make_item(FUNC_NOISE, 32767, 0, 0, 0));
    pending_items.push_back(make_item(FUNC_NOISE, -32768, 0, 0, 0));
    pending_items.push_back(make_item(FUNC_NOISE, -32768, 0, 0, 0));
    pending_items.push_back(make_item(FUNC_NOISE, -32768, 0, 0, 0));
    wait_idle();

    // Shrink the vector in the middle of a step
    configure(8, 8, 4);
    pending_items.push_back(make_item(FUNC_NOISE, 100, 0, 0, 0));
    pending_items.push_back(make_item(FUNC_NOISE, -200, 0, 0, 0));
    wait_idle();
    write_reg(REG_DIMENSION, 2);
    pending_items.push_back(make_item(FUNC_NOISE, 300, 0, 0, 0));
    wait_idle();

    // Grow the vector in the middle of a step
    pending_items.push_back(make_item(FUNC_NOISE, -5, 0, 0, 0));
    wait_idle();
    write_reg(REG_DIMENSION, 4);
    pending_items.push_back(make_item(FUNC_NOISE, 7, 0, 0, 0));
    pending_items.push_back(make_item(FUNC_NOISE, 8, 0, 0, 0));
    pending_items.push_back(make_item(FUNC_NOISE, 9, 0, 0, 0));
    wait_idle();

    // Random items over a range of settings and flow-control patterns
    random_phase(8, 8, 4, IDLE_NONE, 1'b1);
    random_phase(0, 0, 1, IDLE_SENDER, 1'b0);
    random_phase(8, 0, 3, IDLE_RECEIVER, 1'b0);
    random_phase(0, 8, 2, IDLE_BOTH, 1'b0);
    random_phase($urandom_range(8), $urandom_range(8), $urandom_range(4, 1), IDLE_NONE, 1'b0);
    random_phase($urandom_range(8), $urandom_range(8), $urandom_range(4, 1), IDLE_SENDER, 1'b0);
    random_phase($urandom_range(8), $urandom_range(8), $urandom_range(4, 1), IDLE_RECEIVER,
                 1'b0);
    random_phase(8, 8, 4, IDLE_BOTH, 1'b0);
    wait_idle();

    $display("Run: %0d input items, %0d results (%0d clipped), %0d register writes, %0d settings",
             items_in, results_seen, sat_seen, reg_writes, settings_run);
    $display("Run: orders 0..8, dimensions 1..4, mid-step resizing, long output hold-off");
    if (mismatches == 0 && expected_outputs.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Mismatches: %0d, results still expected: %0d", mismatches,
               expected_outputs.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/vaf_pkg.sv
sv/vaf_coef_mem.sv
sv/vaf_mac.sv
sv/vector_arma_filter.sv
tb/sv/tb_top.sv
